// File: hdl/i2r_pkg.sv
// ----------------------------------------------------------------------------
// i2r_pkg
// Shared types, letter codes and digit pattern functions for the
// integer to Roman numeral encoder.
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int unsigned ValW  = 12;
  localparam int unsigned SymW  = 7;
  localparam int unsigned DigW  = 4;
  localparam int unsigned NDig  = 4;
  localparam int unsigned MaxVal = 3999;

  localparam logic [SymW-1:0] SYM_NONE = 7'h00;
  localparam logic [SymW-1:0] SYM_I    = 7'h49;
  localparam logic [SymW-1:0] SYM_V    = 7'h56;
  localparam logic [SymW-1:0] SYM_X    = 7'h58;
  localparam logic [SymW-1:0] SYM_L    = 7'h4C;
  localparam logic [SymW-1:0] SYM_C    = 7'h43;
  localparam logic [SymW-1:0] SYM_D    = 7'h44;
  localparam logic [SymW-1:0] SYM_M    = 7'h4D;

  // digit positions, most significant first
  localparam logic [1:0] POS_THOU = 2'd0;
  localparam logic [1:0] POS_HUND = 2'd1;
  localparam logic [1:0] POS_TENS = 2'd2;
  localparam logic [1:0] POS_UNIT = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SPLIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic split;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic split_last;
    logic emit_last;
    logic out_free;
  } sts_t;

  // number of letters a digit produces at a position
  function automatic logic [2:0] dig_len(input logic [1:0] pos, input logic [DigW-1:0] d);
    logic [2:0] n;
    n = 3'd0;
    if (pos == POS_THOU) begin
      n = d[2:0];
    end else begin
      unique case (d)
        4'd0:    n = 3'd0;
        4'd1:    n = 3'd1;
        4'd2:    n = 3'd2;
        4'd3:    n = 3'd3;
        4'd4:    n = 3'd2;
        4'd5:    n = 3'd1;
        4'd6:    n = 3'd2;
        4'd7:    n = 3'd3;
        4'd8:    n = 3'd4;
        4'd9:    n = 3'd2;
        default: n = 3'd0;
      endcase
    end
    return n;
  endfunction

  // letter number j of digit d at a position
  function automatic logic [SymW-1:0] dig_sym(input logic [1:0] pos,
                                              input logic [DigW-1:0] d,
                                              input logic [1:0] j);
    logic [SymW-1:0] one;
    logic [SymW-1:0] five;
    logic [SymW-1:0] ten;
    logic [SymW-1:0] s;
    unique case (pos)
      POS_THOU: begin one = SYM_M; five = SYM_M; ten = SYM_M; end
      POS_HUND: begin one = SYM_C; five = SYM_D; ten = SYM_M; end
      POS_TENS: begin one = SYM_X; five = SYM_L; ten = SYM_C; end
      default:  begin one = SYM_I; five = SYM_V; ten = SYM_X; end
    endcase
    if (pos == POS_THOU) begin
      s = one;
    end else if (d == 4'd4) begin
      s = (j == 2'd0) ? one : five;
    end else if (d == 4'd9) begin
      s = (j == 2'd0) ? one : ten;
    end else if (d >= 4'd5) begin
      s = (j == 2'd0) ? five : one;
    end else begin
      s = one;
    end
    return s;
  endfunction

endpackage

// File: hdl/integer_to_roman_encoder_top.sv
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top
// Converts a binary number to its Roman numeral, one ASCII letter per beat.
// ----------------------------------------------------------------------------
// One number at a time. A valid number (1 to 3999) is accepted, split into
// decimal digits (thousands, hundreds and tens one per cycle through a shared
// compare-and-subtract unit, the units digit as the remainder left with the
// tens), then emitted as its letters, one per beat, holding while the output
// stalls. Out-of-range input (0 or above 3999) gives one beat with symbol 0,
// last and error set. A new number is accepted while the final letter of the
// previous one still sits in the output register.
module integer_to_roman_encoder_top import i2r_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [ValW-1:0] value,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [SymW-1:0] symbol,
  output logic            last,
  output logic            error
);

  cmd_t cmd;
  sts_t sts;

  i2r_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2r_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last),
    .error     (error)
  );

endmodule

// File: hdl/i2r_ctrl.sv
// ----------------------------------------------------------------------------
// i2r_ctrl
// Sequencer: accept a number, split it into digits, then emit letters (an out-of-range number skips the split).
// ----------------------------------------------------------------------------
module i2r_ctrl import i2r_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = sts.bad ? S_EMIT : S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (sts.split_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free && sts.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_SPLIT: cmd.split = 1'b1;
      S_EMIT:  cmd.emit  = sts.out_free;
      default: ;
    endcase
  end

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && sts.emit_last |=> state == S_IDLE)
    else $error("final letter did not return to idle");

  a_load_in_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> state == S_IDLE && in_valid)
    else $error("load outside idle");

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one command at once");

endmodule

// File: hdl/i2r_dp.sv
// ----------------------------------------------------------------------------
// i2r_dp
// Digit split (one decimal digit per cycle, the units digit with the tens),
// letter generation and output register.
// ----------------------------------------------------------------------------
module i2r_dp import i2r_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cmd_t            cmd,
  output sts_t            sts,
  input  logic [ValW-1:0] value,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [SymW-1:0] symbol,
  output logic            last,
  output logic            error
);

  logic [ValW-1:0] rem;
  logic [ValW-1:0] rem_next;
  logic [1:0]      step;
  logic [DigW-1:0] dig [NDig];
  logic [DigW-1:0] dig_next;
  logic [NDig-1:0] mask;
  logic [1:0]      j;
  logic            err;

  logic [13:0]     mult;
  logic [13:0]     sub;

  logic [1:0]      pos;
  logic [DigW-1:0] cur;
  logic [2:0]      len;
  logic            dig_end;
  logic [NDig-1:0] others;
  logic [SymW-1:0] sym_cur;

  // largest multiple of the current scale not above the remainder
  always_comb begin
    dig_next = '0;
    sub      = '0;
    for (int k = 1; k <= 9; k++) begin
      unique case (step)
        2'd0:    mult = 14'(k * 1000);
        2'd1:    mult = 14'(k * 100);
        default: mult = 14'(k * 10);
      endcase
      if ({2'b00, rem} >= mult) begin
        dig_next = DigW'(k);
        sub      = mult;
      end
    end
    rem_next = rem - sub[ValW-1:0];
  end

  always_comb begin
    pos = POS_UNIT;
    for (int p = NDig - 1; p >= 0; p--) begin
      if (mask[p]) begin
        pos = 2'(p);
      end
    end
  end

  assign cur     = dig[pos];
  assign len     = dig_len(pos, cur);
  assign sym_cur = dig_sym(pos, cur, j);
  assign dig_end = ({1'b0, j} == len - 3'd1);
  assign others  = mask & ~(NDig'(1) << pos);

  assign sts.bad        = (value == '0) || (value > ValW'(MaxVal));
  assign sts.split_last = (step == 2'd2);
  assign sts.emit_last  = err || (dig_end && (others == '0));
  assign sts.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
      err  <= 1'b0;
      step <= '0;
      j    <= '0;
    end else if (cmd.load) begin
      rem  <= value;
      err  <= sts.bad;
      step <= '0;
      mask <= '0;
      j    <= '0;
    end else if (cmd.split) begin
      rem          <= rem_next;
      step         <= step + 2'd1;
      dig[step]    <= dig_next;
      mask[step]   <= (dig_next != '0);
      if (step == 2'd2) begin
        dig[POS_UNIT]  <= rem_next[DigW-1:0];
        mask[POS_UNIT] <= (rem_next != '0);
      end
    end else if (cmd.emit && !err) begin
      if (dig_end) begin
        mask[pos] <= 1'b0;
        j         <= '0;
      end else begin
        j <= j + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      symbol <= err ? SYM_NONE : sym_cur;
      last   <= sts.emit_last;
      error  <= err;
    end
  end

  a_emit_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (err || mask != '0))
    else $error("letter emitted with no digit pending");

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last && symbol == SYM_NONE)
    else $error("error beat malformed");

  a_digits_range: assert property (@(posedge clk) disable iff (rst)
    cmd.split && sts.split_last |=>
      dig[POS_THOU] <= 4'd3 && dig[POS_HUND] <= 4'd9 &&
      dig[POS_TENS] <= 4'd9 && dig[POS_UNIT] <= 4'd9)
    else $error("decimal digit out of range after split");

endmodule

// File: tb/sv/integer_to_roman_encoder_top_test.sv
// ----------------------------------------------------------------------------
// integer_to_roman_encoder_top_test
// Self-checking bench for the integer to Roman numeral encoder. A directed
// table covers the range ends, every digit pattern and the out-of-range codes.
// Random numbers follow under three idle mixes and one long output hold-off.
// Every output beat is checked against the table's numeral or one spelled
// from the accepted number.
// ----------------------------------------------------------------------------
module integer_to_roman_encoder_top_test import i2r_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NDir       = 24;
  localparam int PhaseLen   = 112;
  localparam int HoldCycles = 300;
  localparam int TailCycles = 24;
  localparam int CycleLimit = 400000;
  localparam int MaxPrinted = 40;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            error;
  } beat_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            in_valid;
  logic            in_ready;
  logic [ValW-1:0] value;
  logic            out_valid;
  logic            out_ready;
  logic [SymW-1:0] symbol;
  logic            last;
  logic            error;

  // "?" spells the numeral from the number, "" is the out-of-range beat
  logic [ValW-1:0] dir_value [NDir] = '{
    12'd1, 12'd3999, 12'd3888, 12'd0, 12'd4000, 12'd4095, 12'd1000, 12'd3000,
    12'd4, 12'd9, 12'd5, 12'd8, 12'd500, 12'd2048, 12'd40, 12'd90,
    12'd400, 12'd900, 12'd444, 12'd1994, 12'd3494, 12'd2730, 12'd1365, 12'd4001
  };
  string dir_want [NDir] = '{
    "I", "MMMCMXCIX", "MMMDCCCLXXXVIII", "", "", "", "M", "MMM",
    "IV", "IX", "V", "VIII", "D", "?", "?", "?",
    "?", "?", "?", "?", "?", "?", "?", ""
  };

  beat_t           numeral_q [$];
  string           want_q [$];
  logic [SymW-1:0] letters [16];
  int              n_letters;
  int              mismatches = 0;
  int              send_idle_pct = 27;
  int              recv_idle_pct = 76;
  logic            hold_req = 1'b0;
  int              cycles = 0;

  integer_to_roman_encoder_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .symbol    (symbol),
    .last      (last),
    .error     (error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int got, input int exp);
    mismatches++;
    if (mismatches <= MaxPrinted) begin
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, exp);
    end
  endtask

  task automatic add_letter(input logic [SymW-1:0] s);
    letters[n_letters] = s;
    n_letters++;
  endtask

  task automatic add_digit(input logic [3:0] d, input logic [SymW-1:0] one,
                           input logic [SymW-1:0] five, input logic [SymW-1:0] ten);
    logic [3:0] r;
    r = d;
    if (d == 4'd4) begin
      add_letter(one);
      add_letter(five);
    end else if (d == 4'd9) begin
      add_letter(one);
      add_letter(ten);
    end else begin
      if (d >= 4'd5) begin
        add_letter(five);
        r = d - 4'd5;
      end
      for (int k = 0; k < r; k++) add_letter(one);
    end
  endtask

  // leaves n_letters at 0 for numbers out of range
  task automatic spell_numeral(input logic [ValW-1:0] v);
    int unsigned n;
    n = v;
    n_letters = 0;
    if (n != 0 && n <= MaxVal) begin
      repeat (n / 1000) add_letter(SYM_M);
      add_digit(4'((n / 100) % 10), SYM_C, SYM_D, SYM_M);
      add_digit(4'((n / 10) % 10), SYM_X, SYM_L, SYM_C);
      add_digit(4'(n % 10), SYM_I, SYM_V, SYM_X);
    end
  endtask

  task automatic queue_numeral();
    beat_t b;
    if (n_letters == 0) begin
      b = '{symbol: SYM_NONE, last: 1'b1, error: 1'b1};
      numeral_q = {numeral_q, b};
    end else begin
      for (int i = 0; i < n_letters; i++) begin
        b = '{symbol: letters[i], last: (i == n_letters - 1), error: 1'b0};
        numeral_q = {numeral_q, b};
      end
    end
  endtask

  function automatic logic [ValW-1:0] pick_value();
    int unsigned sel;
    int unsigned n;
    sel = $urandom_range(99);
    if (sel < 8) begin
      n = ($urandom_range(1) == 0) ? 0 : $urandom_range(4095, MaxVal + 1);
    end else if (sel < 18) begin
      n = $urandom_range(99, 1);
    end else if (sel < 30) begin
      // long numerals: hundreds, tens and units of 3 or 8
      n = 1000 * $urandom_range(3, 1) + 100 * ($urandom_range(1) ? 8 : 3)
        + 10 * ($urandom_range(1) ? 8 : 3) + ($urandom_range(1) ? 8 : 3);
    end else begin
      n = $urandom_range(MaxVal, 1);
    end
    return ValW'(n);
  endfunction

  task automatic send_value(input logic [ValW-1:0] v, input string want);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    want_q = {want_q, want};
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  always @(posedge clk) begin
    beat_t exp_beat;
    string want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = want_q.pop_front();
        if (want == "?") begin
          spell_numeral(value);
        end else begin
          n_letters = 0;
          for (int i = 0; i < want.len(); i++) add_letter(SymW'(want[i]));
        end
        queue_numeral();
      end
      if (out_valid && out_ready) begin
        if (numeral_q.size() == 0) begin
          report_mismatch("unexpected beat, symbol", symbol, 0);
        end else begin
          exp_beat = numeral_q.pop_front();
          if (symbol !== exp_beat.symbol) report_mismatch("symbol", symbol, exp_beat.symbol);
          if (last !== exp_beat.last) report_mismatch("last", last, exp_beat.last);
          if (error !== exp_beat.error) report_mismatch("error", error, exp_beat.error);
        end
      end
    end
  end

  // receiver; a hold request parks out_ready low for a long stretch
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req <= 1'b0;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    in_valid <= 1'b0;
    value    <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDir; i++) send_value(dir_value[i], dir_want[i]);

    for (int p = 0; p < 3; p++) begin
      send_idle_pct  = (p == 0) ? 27 : (p == 1) ? 76 : 0;
      recv_idle_pct <= (p == 0) ? 76 : (p == 1) ? 27 : 0;
      if (p == 2) hold_req <= 1'b1;
      for (int i = 0; i < PhaseLen; i++) send_value(pick_value(), "?");
    end
    in_valid <= 1'b0;

    while (numeral_q.size() != 0 || want_q.size() != 0) @(negedge clk);
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/i2r_pkg.sv
hdl/i2r_ctrl.sv
hdl/i2r_dp.sv
hdl/integer_to_roman_encoder_top.sv
tb/sv/integer_to_roman_encoder_top_test.sv
